### rtl/core/textured_column_shader_top_assert.svh
// Assertion macros shared by the column shader files.
// Each macro expects clk and rst in scope.
`ifndef TEXTURED_COLUMN_SHADER_TOP_ASSERT_SVH
`define TEXTURED_COLUMN_SHADER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCS_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcs: same-cycle check failed");
`define TCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcs: next-cycle check failed");
`else
`define TCS_ASSERT_HOLDS(lbl, ante, cons)
`define TCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/tcs_pkg.sv
package tcs_pkg;

  // field widths
  localparam int ROW_W     = 11;
  localparam int WH_W      = 16;
  localparam int COL_W     = 6;
  localparam int ADDR_W    = 12;
  localparam int COLOR_W   = 32;
  localparam int SH_W      = 12;
  localparam int CFG_IDX_W = 2;
  // screen height up to 4095, before and after saturation
  localparam int HGT_W     = 13;
  // row - H/2 + wh/2 with sign bit
  localparam int NUM_W     = 18;
  localparam int TEX_DEPTH = 4096;

  localparam int TEX_SIZE_DEF = 64;
  localparam int MAX_ROWS_DEF = 2048;

  localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKY_COLOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR   = 2'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SHADE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_SKY   = 2'd0,
    REG_WALL  = 2'd1,
    REG_FLOOR = 2'd2,
    REG_NONE  = 2'd3
  } region_t;

  // request fields that ride alongside the texel row divider
  typedef struct packed {
    op_t                op;
    region_t            region;
    logic [COL_W-1:0]   col;
    logic [ADDR_W-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
  } side_t;

endpackage

### rtl/core/tcs_texrow_div.sv
`include "textured_column_shader_top_assert.svh"

// Pipelined restoring divider: trow = min(num * TEX_SIZE / wh, TEX_SIZE-1),
// zero for negative num. One quotient bit per stage.
module tcs_texrow_div
  import tcs_pkg::*;
#(
  parameter int TEX_SIZE = TEX_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  side_t                        in_side,
  input  logic [NUM_W-1:0]             in_num,
  input  logic [WH_W-1:0]              in_wh,
  output logic                         out_valid,
  output side_t                        out_side,
  output logic [$clog2(TEX_SIZE)-1:0]  out_trow
);

  localparam int QB = $clog2(TEX_SIZE);

  logic [QB:0]       v;
  side_t             side [QB+1];
  logic              sat  [QB+1];
  logic [WH_W-1:0]   wh   [QB+1];
  logic [WH_W-1:0]   rem  [QB+1];
  logic [QB-1:0]     q    [QB+1];

  logic [WH_W-1:0]   rem_next [QB];
  logic [QB-1:0]     q_next   [QB];

  logic              num_neg;
  logic              num_sat;

  // range check on entry: negative clamps to zero, num >= wh saturates
  assign num_neg = in_num[NUM_W-1];
  assign num_sat = !num_neg && (in_num[NUM_W-2:0] >= (NUM_W-1)'(in_wh));

  // one restoring step per stage
  always_comb begin
    logic [WH_W:0] r2;
    logic          ge;
    for (int k = 0; k < QB; k++) begin
      r2 = {rem[k], 1'b0};
      ge = r2 >= {1'b0, wh[k]};
      rem_next[k] = ge ? WH_W'(r2 - {1'b0, wh[k]}) : r2[WH_W-1:0];
      q_next[k]   = {q[k][QB-2:0], ge};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QB-1:0], in_valid};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      sat[0]  <= num_sat;
      wh[0]   <= in_wh;
      rem[0]  <= (num_neg || num_sat) ? '0 : in_num[WH_W-1:0];
      q[0]    <= '0;
      for (int k = 0; k < QB; k++) begin
        side[k+1] <= side[k];
        sat[k+1]  <= sat[k];
        wh[k+1]   <= wh[k];
        rem[k+1]  <= rem_next[k];
        q[k+1]    <= q_next[k];
      end
    end
  end

  assign out_valid = v[QB];
  assign out_side  = side[QB];
  assign out_trow  = sat[QB] ? '1 : q[QB];

  `TCS_ASSERT_HOLDS(a_wh_nonzero, v[0], wh[0] != '0)
  `TCS_ASSERT_HOLDS(a_rem_entry, v[0] && !sat[0], rem[0] < wh[0])
  `TCS_ASSERT_NEXT(a_rem_step, en && v[0] && !sat[0], rem[1] < wh[1])
  `TCS_ASSERT_HOLDS(a_rem_exit, v[QB] && !sat[QB], rem[QB] < wh[QB])

endmodule

### rtl/core/textured_column_shader_top.sv
// Textured wall column shader. Each shade request returns one pixel: sky
// above span_start, a texel from the 4096 x 32 texture memory from
// span_start up to span_end, nothing on span_end itself, floor below it,
// nothing at or past the screen height. Write requests load one texel
// and return nothing. Throughput is one request per clock unless stalled.
// Requests pass the texel row divider, retiring one quotient bit per
// stage, then the texture read stage and the output register.
// The whole pipeline advances whenever the output register is empty or
// taken, so s_tready drops only while a result waits. Texel writes pass down
// the pipeline and hit the single-port memory in the same stage as reads,
// so requests take effect in arrival order. A texel never written reads as
// an arbitrary value. Configuration must be written only while the block is
// idle.
`include "textured_column_shader_top_assert.svh"

module textured_column_shader_top
  import tcs_pkg::*;
#(
  parameter int TEX_SIZE = TEX_SIZE_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COLOR_W-1:0]    cfg_data,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // row[10:0], span_start[21:11], span_end[32:22], wall_height[48:33],
  // tex_column[54:49], texel_index[66:55], texel_color[98:67], zero[103:99]
  input  logic [103:0]          s_tdata,
  // operation[0]
  input  logic                  s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_color[31:0]
  output logic [COLOR_W-1:0]    m_tdata,
  // region[1:0]
  output logic [1:0]            m_tuser
);

  localparam int QB = $clog2(TEX_SIZE);

  logic [SH_W-1:0]     screen_height;
  logic [COLOR_W-1:0]  sky_color;
  logic [COLOR_W-1:0]  floor_color;

  logic                adv;

  logic [ROW_W-1:0]    in_row;
  logic [ROW_W-1:0]    in_start;
  logic [ROW_W-1:0]    in_end;
  logic [WH_W-1:0]     in_wh;
  logic [WH_W-1:0]     wh_eff;
  logic [HGT_W-1:0]    height;
  logic [HGT_W-2:0]    half_h;
  logic [NUM_W-1:0]    num;
  region_t             in_region;
  side_t               in_side;

  logic                dv;
  side_t               dside;
  logic [QB-1:0]       trow;
  logic [2*QB-1:0]     trow_scaled;
  logic [ADDR_W-1:0]   taddr;

  logic [COLOR_W-1:0]  tex_mem [TEX_DEPTH];
  logic [COLOR_W-1:0]  rd;
  logic                mv;
  op_t                 mop;
  region_t             mregion;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= SCREEN_HEIGHT_RST;
      sky_color     <= '0;
      floor_color   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SH_W-1:0];
        CFG_SKY_COLOR:     sky_color     <= cfg_data;
        CFG_FLOOR_COLOR:   floor_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take a result
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // request unpacking
  assign in_row   = s_tdata[10:0];
  assign in_start = s_tdata[21:11];
  assign in_end   = s_tdata[32:22];
  assign in_wh    = s_tdata[48:33];

  // effective screen height and texel row numerator
  assign height = ({1'b0, screen_height} > HGT_W'(MAX_ROWS)) ? HGT_W'(MAX_ROWS)
                                                              : {1'b0, screen_height};
  assign half_h = height[HGT_W-1:1];
  assign wh_eff = (in_wh == '0) ? WH_W'(1) : in_wh;
  assign num    = NUM_W'(in_row) - NUM_W'(half_h) + NUM_W'(wh_eff[WH_W-1:1]);

  // region decision, first match wins
  always_comb begin
    priority if (HGT_W'(in_row) >= height) begin
      in_region = REG_NONE;
    end else if (in_row < in_start) begin
      in_region = REG_SKY;
    end else if (in_row < in_end) begin
      in_region = REG_WALL;
    end else if (in_row == in_end) begin
      in_region = REG_NONE;
    end else if (in_row != '0) begin
      in_region = REG_FLOOR;
    end else begin
      in_region = REG_NONE;
    end
  end

  always_comb begin
    in_side        = '0;
    in_side.op     = op_t'(s_tuser);
    in_side.region = in_region;
    in_side.col    = s_tdata[54:49];
    in_side.waddr  = s_tdata[66:55];
    in_side.wdata  = s_tdata[98:67];
  end

  tcs_texrow_div #(
    .TEX_SIZE (TEX_SIZE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .in_side   (in_side),
    .in_num    (num),
    .in_wh     (wh_eff),
    .out_valid (dv),
    .out_side  (dside),
    .out_trow  (trow)
  );

  // texel address, wraps at the memory depth
  assign trow_scaled = {trow, QB'(0)};
  assign taddr       = ADDR_W'(trow_scaled) + ADDR_W'(dside.col);

  // texture memory: writes and reads share one stage
  always_ff @(posedge clk) begin
    if (adv && dv) begin
      if (dside.op == OP_WRITE) begin
        tex_mem[dside.waddr] <= dside.wdata;
      end else begin
        rd <= tex_mem[taddr];
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mop     <= dside.op;
      mregion <= dside.region;
    end
  end

  // output register, shade requests only
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= mv && (mop == OP_SHADE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= mregion;
      unique case (mregion)
        REG_SKY:   m_tdata <= sky_color;
        REG_WALL:  m_tdata <= rd;
        REG_FLOOR: m_tdata <= floor_color;
        REG_NONE:  m_tdata <= '0;
        default:   m_tdata <= '0;
      endcase
    end
  end

  `TCS_ASSERT_HOLDS(a_none_is_zero, m_tvalid && (m_tuser == REG_NONE), m_tdata == '0)
  `TCS_ASSERT_HOLDS(a_sky_matches, m_tvalid && (m_tuser == REG_SKY), m_tdata == sky_color)
  `TCS_ASSERT_HOLDS(a_floor_matches, m_tvalid && (m_tuser == REG_FLOOR), m_tdata == floor_color)
  `TCS_ASSERT_HOLDS(a_load_on_advance, $rose(m_tvalid), $past(s_tready))

endmodule

### tb/textured_column_shader_top_test.sv
module textured_column_shader_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcs_pkg::*;

  localparam int LAT = $clog2(TEX_SIZE_DEF) + 2;

  typedef struct {
    op_t                op;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   span_start;
    logic [ROW_W-1:0]   span_end;
    logic [WH_W-1:0]    wall_height;
    logic [COL_W-1:0]   tex_column;
    logic [ADDR_W-1:0]  texel_index;
    logic [COLOR_W-1:0] texel_color;
  } shader_req_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    region_t            region;
  } pixel_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_HEIGHT;
  logic [COLOR_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [103:0]         s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [COLOR_W-1:0]   m_tdata;
  logic [1:0]           m_tuser;

  // shadow of the block's registers and texture memory
  logic [SH_W-1:0]    scr_height = SCREEN_HEIGHT_RST;
  logic [COLOR_W-1:0] sky_color = '0;
  logic [COLOR_W-1:0] floor_color = '0;
  logic [COLOR_W-1:0] texmem [TEX_DEPTH];
  bit                 texel_written [TEX_DEPTH];

  pixel_t expected_pixels [$];
  int     fail_count = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;

  textured_column_shader_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic int eff_height();
    return (scr_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(scr_height);
  endfunction

  // exact texel row, floored and clamped, folded into a texture address
  function automatic logic [ADDR_W-1:0] texel_addr(shader_req_t req);
    int w, num, t;
    w = (req.wall_height == 0) ? 1 : int'(req.wall_height);
    num = int'(req.row) - eff_height() / 2 + w / 2;
    if (num < 0) t = 0;
    else t = (num * TEX_SIZE_DEF) / w;
    if (t > TEX_SIZE_DEF - 1) t = TEX_SIZE_DEF - 1;
    return ADDR_W'(TEX_SIZE_DEF * t + int'(req.tex_column));
  endfunction

  function automatic pixel_t shade_pixel(shader_req_t req);
    pixel_t px;
    px.color = '0;
    px.region = REG_NONE;
    if (int'(req.row) >= eff_height()) begin
      px.region = REG_NONE;
    end else if (req.row < req.span_start) begin
      px.region = REG_SKY;
      px.color = sky_color;
    end else if (req.row < req.span_end) begin
      px.region = REG_WALL;
      px.color = texmem[texel_addr(req)];
    end else if (req.row == req.span_end) begin
      px.region = REG_NONE;
    end else if (req.row > 0) begin
      px.region = REG_FLOOR;
      px.color = floor_color;
    end
    return px;
  endfunction

  // ---------------------------------------------------------------- driving

  // send one request, then update the shadow state on acceptance
  task automatic send_req(input shader_req_t req);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.op;
    s_tdata  <= {5'd0, req.texel_color, req.texel_index, req.tex_column,
                 req.wall_height, req.span_end, req.span_start, req.row};
    do @(posedge clk); while (!s_tready);
    if (req.op == OP_WRITE) begin
      texmem[req.texel_index] = req.texel_color;
      texel_written[req.texel_index] = 1'b1;
    end else begin
      expected_pixels.push_back(shade_pixel(req));
    end
  endtask

  // shade request; a wall pixel on a fresh texel gets that texel loaded first
  task automatic shade(input shader_req_t req);
    shader_req_t fill;
    pixel_t px;
    logic [ADDR_W-1:0] addr;
    req.op = OP_SHADE;
    px = shade_pixel(req);
    addr = texel_addr(req);
    if (px.region == REG_WALL && !texel_written[addr]) begin
      fill = req;
      fill.op = OP_WRITE;
      fill.texel_index = addr;
      fill.texel_color = $urandom();
      send_req(fill);
    end
    send_req(req);
  endtask

  function automatic shader_req_t pixel_req(int row, int span_start, int span_end,
                                            int wall_height, int tex_column);
    shader_req_t req;
    req.op = OP_SHADE;
    req.row = ROW_W'(row);
    req.span_start = ROW_W'(span_start);
    req.span_end = ROW_W'(span_end);
    req.wall_height = WH_W'(wall_height);
    req.tex_column = COL_W'(tex_column);
    req.texel_index = ADDR_W'($urandom());
    req.texel_color = $urandom();
    return req;
  endfunction

  function automatic shader_req_t write_req(int index, logic [COLOR_W-1:0] color);
    shader_req_t req;
    req = pixel_req($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    req.op = OP_WRITE;
    req.texel_index = ADDR_W'(index);
    req.texel_color = color;
    return req;
  endfunction

  // wait for all results, then let trailing texel writes leave the pipeline
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SCREEN_HEIGHT: scr_height = val[SH_W-1:0];
      CFG_SKY_COLOR:     sky_color = val;
      CFG_FLOOR_COLOR:   floor_color = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int height, input logic [COLOR_W-1:0] sky,
                            input logic [COLOR_W-1:0] flr);
    quiesce();
    write_reg(CFG_SCREEN_HEIGHT, COLOR_W'(height));
    write_reg(CFG_SKY_COLOR, sky);
    write_reg(CFG_FLOOR_COLOR, flr);
  endtask

  function automatic logic [ROW_W-1:0] clamp_row(int v);
    if (v < 0) return '0;
    if (v > 2047) return 11'd2047;
    return ROW_W'(v);
  endfunction

  // mostly realistic column pixels, some texel loads, some raw noise
  task automatic random_request();
    shader_req_t req;
    int h, k, wh, lo, hi;
    h = (eff_height() == 0) ? 1 : eff_height();
    req = write_req($urandom(), $urandom());
    req.row = ROW_W'($urandom());
    req.span_start = ROW_W'($urandom());
    req.span_end = ROW_W'($urandom());
    req.wall_height = WH_W'($urandom());
    req.tex_column = COL_W'($urandom());
    k = $urandom_range(99);
    if (k < 10) begin
      send_req(req);
    end else if (k < 85) begin
      if ($urandom_range(9) == 0) wh = $urandom_range(65535);
      else wh = $urandom_range(1, 2 * h);
      lo = h / 2 - wh / 2;
      hi = h / 2 + wh / 2;
      if (hi > h - 1) hi = h - 1;
      req.wall_height = WH_W'(wh);
      req.span_start = clamp_row(lo);
      req.span_end = clamp_row(hi);
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: req.row = clamp_row(lo - 1);
          1: req.row = clamp_row(lo);
          2: req.row = clamp_row(hi - 1);
          3: req.row = clamp_row(hi);
          default: req.row = clamp_row(hi + 1);
        endcase
      end else begin
        req.row = clamp_row($urandom_range(0, h + 1));
      end
      shade(req);
    end else begin
      shade(req);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_pixels
    pixel_t px;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_color %h region %0d", m_tdata, m_tuser);
        fail_count++;
      end else begin
        px = expected_pixels.pop_front();
        if (m_tdata !== px.color) begin
          $error("pixel_color mismatch: expected %h, got %h", px.color, m_tdata);
          fail_count++;
        end
        if (m_tuser !== px.region) begin
          $error("region mismatch: expected %0d, got %0d", px.region, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset configuration: 480 rows, black sky and floor
  task automatic test_reset_defaults();
    shade(pixel_req(0, 0, 0, 64, 0));
    shade(pixel_req(479, 10, 100, 64, 5));
    shade(pixel_req(480, 0, 900, 64, 5));
    shade(pixel_req(240, 200, 300, 100, 7));
  endtask

  task automatic test_special_cases();
    // screen height above the row limit saturates
    set_config(4095, 32'hFFFF_FFFF, 32'h0);
    send_req(write_req(0, 32'h0));
    send_req(write_req(TEX_DEPTH - 1, 32'hFFFF_FFFF));
    shade(pixel_req(2047, 0, 100, 64, 0));
    shade(pixel_req(2047, 0, 2047, 64, 0));
    shade(pixel_req(5, 10, 20, 64, 0));
    // inverted span: sky wins, then floor
    shade(pixel_req(15, 20, 10, 64, 0));
    shade(pixel_req(25, 20, 10, 64, 0));
    // zero wall height, texel row clamped low and high
    shade(pixel_req(100, 0, 2000, 0, 0));
    shade(pixel_req(1500, 0, 2000, 0, 63));
    shade(pixel_req(0, 0, 10, 65535, 63));
    shade(pixel_req(1024, 0, 2047, 64, 31));
    // empty screen
    set_config(0, 32'h0, 32'hFFFF_FFFF);
    shade(pixel_req(0, 0, 5, 1, 0));
    // single row screen
    set_config(1, 32'h1234_5678, 32'hFFFF_FFFF);
    shade(pixel_req(0, 0, 5, 1, 9));
    shade(pixel_req(0, 1, 5, 1, 9));
  endtask

  task automatic test_random_traffic(input int n_req, input int idle, input int stall,
                                     input int phase);
    int sel, h;
    logic [COLOR_W-1:0] sky, flr;
    for (int half = 0; half < 2; half++) begin
      sel = phase * 2 + half;
      case (sel)
        0: h = 4095;
        1: h = 480;
        2: h = 1;
        3: h = $urandom_range(1, MAX_ROWS_DEF);
        4: h = 1200;
        5: h = 64;
        6: h = MAX_ROWS_DEF;
        default: h = $urandom_range(0, 4095);
      endcase
      sky = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom();
      flr = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'h0 : $urandom();
      set_config(h, sky, flr);
      src_idle_pct = idle;
      sink_stall_pct = stall;
      repeat (n_req / 2) random_request();
      src_idle_pct = 0;
      sink_stall_pct = 0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_special_cases();
    test_random_traffic(300, 0, 0, 0);
    test_random_traffic(300, 76, 0, 1);
    test_random_traffic(300, 0, 76, 2);
    test_random_traffic(300, 33, 33, 3);
    quiesce();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
